/* src/sgd_momentum_weight_update_assert.svh */
// Assertion macros used by the checker of the weight update block.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef SGD_MOMENTUM_WEIGHT_UPDATE_ASSERT_SVH
`define SGD_MOMENTUM_WEIGHT_UPDATE_ASSERT_SVH

// cons must hold in the same cycle as ante
`define SGDM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sgdm check failed in the same cycle");

// cons must hold in the cycle after ante
`define SGDM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sgdm check failed one cycle later");

`endif

/* src/sgdm_pkg.sv */
`default_nettype none
package sgdm_pkg;

	localparam int DATA_W   = 32;
	localparam int RATE_W   = 16;
	localparam int FUNC_W   = 2;
	localparam int NEURON_W = 4;
	localparam int SLOT_W   = 7;
	localparam int CFG_IDX_W = 2;

	localparam logic [RATE_W-1:0] LEARN_RESET    = 16'd6554;
	localparam logic [RATE_W-1:0] DECAY_RESET    = 16'd0;
	localparam logic [RATE_W-1:0] MOMENTUM_RESET = 16'd0;

	localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

	typedef enum logic [FUNC_W-1:0] {
		FN_WRITE  = 2'd0,
		FN_CLEAR  = 2'd1,
		FN_UPDATE = 2'd2,
		FN_READ   = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEARN    = 2'd0,
		CFG_DECAY    = 2'd1,
		CFG_MOMENTUM = 2'd2
	} cfg_reg_t;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_READ  = 6'b000100,
		ST_MUL   = 6'b001000,
		ST_SUM   = 6'b010000,
		ST_WB    = 6'b100000
	} state_t;

endpackage
`default_nettype wire

/* src/sgd_momentum_weight_update.sv */
`default_nettype none
// SGD weight update with momentum and weight decay for one layer of NEURONS neurons with
// INPUTS inputs each plus a bias. Each transaction on the input channel writes a weight, clears
// a stored step, reads an entry or updates it (step = eta*delta*x - lambda*w + alpha*old_step,
// w += step, x = 1 for the bias slot) and returns one result with the entry's weight and step
// after the operation. Weights and steps live in two single-port synchronous memories of
// NEURONS*(INPUTS+1) entries; one item is worked on at a time, so accesses never overlap.
// Write, clear, read and out-of-range items go through memory read, then write back; an update
// goes through memory read with the eta*delta, lambda*w and alpha*step products, the product with
// x, the saturating step sum, then the saturating weight add and write back. A stalled output adds
// its stall cycles only when a second result is ready before the first is taken. After reset the
// step memory is swept to zero, one entry per cycle, over all NEURONS*(INPUTS+1) entries (1040 by
// default) while in_stall stays high; configuration writes are taken at any time.
module sgd_momentum_weight_update #(
	parameter int NEURONS   = 16,
	parameter int INPUTS    = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [sgdm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sgdm_pkg::RATE_W-1:0]      cfg_data,

	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [sgdm_pkg::FUNC_W-1:0]      func,
	input  logic [sgdm_pkg::NEURON_W-1:0]    neuron,
	input  logic [sgdm_pkg::SLOT_W-1:0]      slot,
	input  logic signed [sgdm_pkg::DATA_W-1:0] value,
	input  logic signed [sgdm_pkg::DATA_W-1:0] delta,

	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [sgdm_pkg::DATA_W-1:0] weight,
	output logic signed [sgdm_pkg::DATA_W-1:0] step,
	output logic                             saturated
);

	localparam int DW      = sgdm_pkg::DATA_W;
	localparam int RW      = sgdm_pkg::RATE_W;
	localparam int ENTRIES = NEURONS * (INPUTS + 1);
	localparam int ADDR_W  = $clog2(ENTRIES);
	localparam int RPROD_W = RW + 1 + DW;
	localparam int XPROD_W = 2 * DW;
	localparam int T1_W    = XPROD_W - FRAC_BITS;
	localparam int SUM_W   = T1_W + 2;

	sgdm_pkg::state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_idx_q;

	logic [RW-1:0] learn_q, decay_q, momentum_q;

	logic [DW-1:0] weight_mem [ENTRIES];
	logic [DW-1:0] step_mem   [ENTRIES];

	logic [sgdm_pkg::FUNC_W-1:0] func_q;
	logic                        hit_q;
	logic                        bias_q;
	logic [ADDR_W-1:0]           addr_q;
	logic signed [DW-1:0]        value_q, delta_q;
	logic signed [DW-1:0]        w_rd_q, s_rd_q;
	logic signed [DW-1:0]        p_q, t2_q, t3_q;
	logic signed [T1_W-1:0]      t1_q;
	logic signed [DW-1:0]        st_q;
	logic                        st_sat_q;

	logic signed [DW-1:0] weight_q, step_q;
	logic                 saturated_q, out_valid_q;

	logic              in_acc, in_hit, out_load;
	logic [ADDR_W-1:0] in_addr;

	logic signed [RPROD_W-1:0] prod_p, prod_t2, prod_t3;
	logic signed [XPROD_W-1:0] prod_x;
	logic signed [T1_W-1:0]    t1_d;
	logic signed [SUM_W-1:0]   sum;
	logic                      sum_sat;
	logic signed [DW-1:0]      st_d;
	logic signed [DW:0]        nw_sum;
	logic                      nw_sat;
	logic signed [DW-1:0]      nw;

	logic              w_we, s_we;
	logic [DW-1:0]     w_wdata, s_wdata;
	logic signed [DW-1:0] res_weight, res_step;
	logic              res_sat;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != sgdm_pkg::ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign in_hit    = (32'(neuron) < NEURONS) && (32'(slot) <= INPUTS);
	assign in_addr   = ADDR_W'(32'(neuron) * (INPUTS + 1) + 32'(slot));
	assign out_load  = (state_q == sgdm_pkg::ST_WB) && (!out_valid_q || !out_stall);

	assign out_valid = out_valid_q;
	assign weight    = weight_q;
	assign step      = step_q;
	assign saturated = saturated_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_q    <= sgdm_pkg::LEARN_RESET;
			decay_q    <= sgdm_pkg::DECAY_RESET;
			momentum_q <= sgdm_pkg::MOMENTUM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sgdm_pkg::CFG_LEARN:    learn_q    <= cfg_data;
				sgdm_pkg::CFG_DECAY:    decay_q    <= cfg_data;
				sgdm_pkg::CFG_MOMENTUM: momentum_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sgdm_pkg::ST_CLEAR: begin
				if (clr_idx_q == ADDR_W'(ENTRIES - 1)) state_d = sgdm_pkg::ST_IDLE;
			end
			sgdm_pkg::ST_IDLE: begin
				if (in_acc) state_d = sgdm_pkg::ST_READ;
			end
			sgdm_pkg::ST_READ: begin
				if (hit_q && func_q == sgdm_pkg::FN_UPDATE) state_d = sgdm_pkg::ST_MUL;
				else state_d = sgdm_pkg::ST_WB;
			end
			sgdm_pkg::ST_MUL: state_d = sgdm_pkg::ST_SUM;
			sgdm_pkg::ST_SUM: state_d = sgdm_pkg::ST_WB;
			sgdm_pkg::ST_WB: begin
				if (out_load) state_d = sgdm_pkg::ST_IDLE;
			end
			default: state_d = sgdm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sgdm_pkg::ST_CLEAR;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sgdm_pkg::ST_CLEAR) clr_idx_q <= clr_idx_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// latch the transaction
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q  <= func;
			hit_q   <= in_hit;
			bias_q  <= (slot == '0);
			addr_q  <= in_addr;
			value_q <= value;
			delta_q <= delta;
		end
	end

	// rate products: floor by arithmetic shift, taken as a part-select
	assign prod_p  = $signed({1'b0, learn_q}) * delta_q;
	assign prod_t2 = $signed({1'b0, decay_q}) * w_rd_q;
	assign prod_t3 = $signed({1'b0, momentum_q}) * s_rd_q;

	assign prod_x = p_q * value_q;
	assign t1_d   = bias_q ? {{(T1_W - DW){p_q[DW-1]}}, p_q} : prod_x[XPROD_W-1:FRAC_BITS];

	assign sum     = SUM_W'(t1_q) - SUM_W'(t2_q) + SUM_W'(t3_q);
	assign sum_sat = !((&sum[SUM_W-1:DW-1]) || !(|sum[SUM_W-1:DW-1]));
	assign st_d    = sum_sat ? (sum[SUM_W-1] ? sgdm_pkg::SAT_MIN : sgdm_pkg::SAT_MAX)
	                         : sum[DW-1:0];

	assign nw_sum = {w_rd_q[DW-1], w_rd_q} + {st_q[DW-1], st_q};
	assign nw_sat = (nw_sum[DW] != nw_sum[DW-1]);
	assign nw     = nw_sat ? (nw_sum[DW] ? sgdm_pkg::SAT_MIN : sgdm_pkg::SAT_MAX)
	                       : nw_sum[DW-1:0];

	always_ff @(posedge clk) begin
		if (state_q == sgdm_pkg::ST_READ) begin
			p_q  <= prod_p[RW+DW-1:RW];
			t2_q <= prod_t2[RW+DW-1:RW];
			t3_q <= prod_t3[RW+DW-1:RW];
		end
		if (state_q == sgdm_pkg::ST_MUL) t1_q <= t1_d;
		if (state_q == sgdm_pkg::ST_SUM) begin
			st_q     <= st_d;
			st_sat_q <= sum_sat;
		end
	end

	always_comb begin
		w_we       = 1'b0;
		s_we       = 1'b0;
		w_wdata    = value_q;
		s_wdata    = '0;
		res_weight = w_rd_q;
		res_step   = s_rd_q;
		res_sat    = 1'b0;
		if (!hit_q) begin
			res_weight = '0;
			res_step   = '0;
		end else begin
			case (func_q)
				sgdm_pkg::FN_WRITE: begin
					w_we       = out_load;
					res_weight = value_q;
				end
				sgdm_pkg::FN_CLEAR: begin
					s_we     = out_load;
					res_step = '0;
				end
				sgdm_pkg::FN_UPDATE: begin
					w_we       = out_load;
					s_we       = out_load;
					w_wdata    = nw;
					s_wdata    = st_q;
					res_weight = nw;
					res_step   = st_q;
					res_sat    = st_sat_q || nw_sat;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (w_we) weight_mem[addr_q] <= w_wdata;
		if (in_acc && in_hit) w_rd_q <= weight_mem[in_addr];
	end

	// the sweep after reset owns the step memory's write port
	always_ff @(posedge clk) begin
		if (state_q == sgdm_pkg::ST_CLEAR) step_mem[clr_idx_q] <= '0;
		else if (s_we) step_mem[addr_q] <= s_wdata;
		if (in_acc && in_hit) s_rd_q <= step_mem[in_addr];
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			weight_q    <= res_weight;
			step_q      <= res_step;
			saturated_q <= res_sat;
		end
	end

endmodule
`default_nettype wire

/* src/sgdm_checker.sv */
`default_nettype none
`include "sgd_momentum_weight_update_assert.svh"

module sgdm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] weight,
	input logic [31:0] step,
	input logic        saturated
);

	`SGDM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(weight) && $stable(step) && $stable(saturated))

	// one item in flight: acceptance closes the input until the result is out
	`SGDM_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall)

	// the step memory sweep holds off input right after reset
	`SGDM_ASSERT_NOW(a_sweep_after_reset, !$past(arst_n), in_stall)

	// a fresh result only comes from an item that was being worked on
	`SGDM_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))

endmodule

bind sgd_momentum_weight_update sgdm_checker u_sgdm_checker (.*);
`default_nettype wire
